// File: rtl/core/ncg_pkg.sv
// Package for the note chord grouper: payload types, config type and constants.
`timescale 1ns / 1ps

package ncg_pkg;

  typedef enum logic [1:0] {
    ACT_NEW = 2'd0,
    ACT_ADD = 2'd1,
    ACT_DUP = 2'd2
  } action_t;

  typedef struct packed {
    logic [31:0] on_time;
    logic [31:0] off_time;
    logic [6:0]  pitch;
  } note_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] chord_start;
  } result_t;

  typedef struct packed {
    logic [15:0] min_duration;
    logic [15:0] thresh_time;
    logic [15:0] fudge_time;
    logic [15:0] ext_time;
  } cfg_t;

  localparam logic [1:0] CFG_MIN_DURATION = 2'd0;
  localparam logic [1:0] CFG_THRESH_TIME  = 2'd1;
  localparam logic [1:0] CFG_FUDGE_TIME   = 2'd2;
  localparam logic [1:0] CFG_EXT_TIME     = 2'd3;

  localparam logic [15:0] MIN_DURATION_RST = 16'd120;
  localparam logic [15:0] THRESH_TIME_RST  = 16'd60;
  localparam logic [15:0] FUDGE_TIME_RST   = 16'd15;
  localparam logic [15:0] EXT_TIME_RST     = 16'd30;

  localparam int WIN_BITS = 17;

endpackage

// File: rtl/core/ncg_core.sv
// Chord state and per-note grouping decision for the note chord grouper.
`timescale 1ns / 1ps

module ncg_core #(
  parameter int TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  ncg_pkg::note_t note,
  input  ncg_pkg::cfg_t  cfg,
  output ncg_pkg::result_t res
);

  localparam int TW = TIME_BITS;
  localparam int WW = ncg_pkg::WIN_BITS;
  localparam int SW = ((TW > WW) ? TW : WW) + 1;

  logic          open_r, open_nxt;
  logic [TW-1:0] open_start_r, open_start_nxt;
  logic [WW-1:0] window_len_r, window_len_nxt;
  logic [TW-1:0] latest_off_r, latest_off_nxt;
  logic [127:0]  pitch_map_r, pitch_map_nxt;

  logic [TW-1:0] on_t, off_t;
  logic [SW-1:0] win_end;
  logic          in_window, overlap, in_fudge, join_chord, dup;
  ncg_pkg::action_t action;

  assign on_t  = TW'(note.on_time);
  assign off_t = TW'(note.off_time);

  assign win_end   = SW'(open_start_r) + SW'(window_len_r);
  assign in_window = SW'(on_t) < win_end;
  assign overlap   = ({1'b0, on_t} + (TW+1)'(cfg.min_duration)) <= {1'b0, latest_off_r};
  assign in_fudge  = (SW'(on_t) + SW'(cfg.fudge_time)) >= win_end;
  assign join_chord = open_r && in_window && overlap;
  assign dup       = pitch_map_r[note.pitch];

  always_comb begin
    open_nxt       = open_r;
    open_start_nxt = open_start_r;
    window_len_nxt = window_len_r;
    latest_off_nxt = latest_off_r;
    pitch_map_nxt  = pitch_map_r;
    action         = ncg_pkg::ACT_NEW;
    if (join_chord) begin
      if (dup) begin
        action = ncg_pkg::ACT_DUP;
      end else begin
        action = ncg_pkg::ACT_ADD;
        pitch_map_nxt[note.pitch] = 1'b1;
        if (off_t > latest_off_r) begin
          latest_off_nxt = off_t;
        end
      end
      // one extension per chord
      if (in_fudge && (window_len_r == WW'(cfg.thresh_time))) begin
        window_len_nxt = window_len_r + WW'(cfg.ext_time);
      end
    end else begin
      open_nxt       = 1'b1;
      open_start_nxt = on_t;
      latest_off_nxt = off_t;
      window_len_nxt = WW'(cfg.thresh_time);
      pitch_map_nxt  = '0;
      pitch_map_nxt[note.pitch] = 1'b1;
    end
  end

  always_comb begin
    res.action      = action;
    res.chord_start = 32'(open_start_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      open_start_r <= '0;
      window_len_r <= '0;
      latest_off_r <= '0;
      pitch_map_r  <= '0;
    end else if (step) begin
      open_r       <= open_nxt;
      open_start_r <= open_start_nxt;
      window_len_r <= window_len_nxt;
      latest_off_r <= latest_off_nxt;
      pitch_map_r  <= pitch_map_nxt;
    end
  end

  a_open_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> open_r)
    else $error("chord not open after a note");

  a_pitch_marked: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> pitch_map_r[$past(note.pitch)])
    else $error("note pitch missing from chord map");

  a_new_window: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !join_chord) |=> (window_len_r == WW'($past(cfg.thresh_time))))
    else $error("new chord window not loaded from threshold");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(pitch_map_r) && $stable(window_len_r) && $stable(open_start_r)))
    else $error("chord state changed without a note");

endmodule

// File: rtl/core/note_chord_grouper.sv
// Top level of the note chord grouper: channels, config registers, pipeline registers.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid / in_ready    | in_data   (ncg_pkg::note_t)
//  out     | out | out_valid / out_ready  | out_data  (ncg_pkg::result_t)
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One note per cycle sustained while out_ready is high; a note passes the input register, then the result register.
// The chord state update is a read-modify-write between input and result regs.
// Reset is synchronous: chord state cleared, config registers loaded with defaults.
// A stalled output holds the input register; in_ready drops only when both are full.
// cfg_ready is always high.
`timescale 1ns / 1ps

module note_chord_grouper #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ncg_pkg::note_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ncg_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  ncg_pkg::cfg_t    cfg_r;
  ncg_pkg::note_t   in_data_r;
  logic             in_valid_r;
  ncg_pkg::result_t out_data_r;
  logic             out_valid_r;
  ncg_pkg::result_t res;
  logic             adv, step;

  assign adv       = !out_valid_r || out_ready;
  assign step      = in_valid_r && adv;
  assign in_ready  = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_duration <= ncg_pkg::MIN_DURATION_RST;
      cfg_r.thresh_time  <= ncg_pkg::THRESH_TIME_RST;
      cfg_r.fudge_time   <= ncg_pkg::FUDGE_TIME_RST;
      cfg_r.ext_time     <= ncg_pkg::EXT_TIME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ncg_pkg::CFG_MIN_DURATION: cfg_r.min_duration <= cfg_data;
        ncg_pkg::CFG_THRESH_TIME:  cfg_r.thresh_time  <= cfg_data;
        ncg_pkg::CFG_FUDGE_TIME:   cfg_r.fudge_time   <= cfg_data;
        ncg_pkg::CFG_EXT_TIME:     cfg_r.ext_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= res;
    end
  end

  ncg_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .note (in_data_r),
    .cfg  (cfg_r),
    .res  (res)
  );

endmodule
